/* design/pdd_pkg.sv */
// ----------------------------------------------------------------------------
// pdd_pkg: shared definitions for the position drive unit
// Field widths, register indexes, reset values and the structs that pass
// between the top level and the control law datapath.
// ----------------------------------------------------------------------------
package pdd_pkg;

    localparam int POS_W      = 16;
    localparam int ERR_W      = POS_W + 1;
    localparam int GAIN_W     = 16;
    localparam int OFS_W      = 10;
    localparam int DRV_W      = 11;
    localparam int DUTY_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_GAIN_X          = 3'd0,
        CFG_D_GAIN_X          = 3'd1,
        CFG_P_GAIN_Y          = 3'd2,
        CFG_D_GAIN_Y          = 3'd3,
        CFG_FRICTION_OFFSET_X = 3'd4,
        CFG_FRICTION_OFFSET_Y = 3'd5,
        CFG_DRIVE_LIMIT       = 3'd6
    } cfg_index_t;

    localparam logic signed [GAIN_W-1:0] RST_P_GAIN_X = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_D_GAIN_X = 16'sd1024;
    localparam logic signed [GAIN_W-1:0] RST_P_GAIN_Y = 16'sd2560;
    localparam logic signed [GAIN_W-1:0] RST_D_GAIN_Y = 16'sd5120;
    localparam logic [OFS_W-1:0]         RST_FRICTION_X = 10'd350;
    localparam logic [OFS_W-1:0]         RST_FRICTION_Y = 10'd250;
    localparam logic [OFS_W-1:0]         RST_DRIVE_LIMIT = 10'd1000;

    // Gains and friction offset of the axis being served.
    typedef struct packed {
        logic signed [GAIN_W-1:0] p_gain;
        logic signed [GAIN_W-1:0] d_gain;
        logic [OFS_W-1:0]         friction;
    } axis_cfg_t;

    // Everything the control law hands back for one request.
    typedef struct packed {
        logic signed [DRV_W-1:0] drive_value;
        logic                    motor_direction;
        logic [DUTY_W-1:0]       motor_duty;
    } law_result_t;

endpackage

/* design/pdd_pos_if.sv */
// ----------------------------------------------------------------------------
// pdd_pos_if: position request channel
// Carries the axis and the measured and target positions of one request.
// ----------------------------------------------------------------------------
interface pdd_pos_if;

    logic                                valid;
    logic                                ready;
    logic                                axis;
    logic signed [pdd_pkg::POS_W-1:0]    measured_position;
    logic signed [pdd_pkg::POS_W-1:0]    target_position;

    modport source (output valid, output axis, output measured_position,
                    output target_position, input ready);
    modport sink   (input valid, input axis, input measured_position,
                    input target_position, output ready);

endinterface

/* design/pdd_drive_if.sv */
// ----------------------------------------------------------------------------
// pdd_drive_if: drive result channel
// Carries the clamped drive and the direction and duty for the motor stage.
// ----------------------------------------------------------------------------
interface pdd_drive_if;

    logic                                valid;
    logic                                ready;
    logic                                axis_out;
    logic signed [pdd_pkg::DRV_W-1:0]    drive_value;
    logic                                motor_direction;
    logic [pdd_pkg::DUTY_W-1:0]          motor_duty;

    modport source (output valid, output axis_out, output drive_value,
                    output motor_direction, output motor_duty, input ready);
    modport sink   (input valid, input axis_out, input drive_value,
                    input motor_direction, input motor_duty, output ready);

endinterface

/* design/pdd_cfg_if.sv */
// ----------------------------------------------------------------------------
// pdd_cfg_if: configuration write channel
// Carries a register index and the data to be written there.
// ----------------------------------------------------------------------------
interface pdd_cfg_if;

    logic                                  valid;
    logic                                  ready;
    logic [pdd_pkg::CFG_IDX_W-1:0]         index;
    logic [pdd_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

/* design/pdd_law.sv */
// ----------------------------------------------------------------------------
// pdd_law: PD control law datapath
// Forms P and D terms, scales them down with truncation toward zero, adds
// the friction offset away from zero, clamps, and derives direction and duty.
// ----------------------------------------------------------------------------
module pdd_law #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                               axis,
    input  pdd_pkg::axis_cfg_t                 axis_cfg,
    input  logic [pdd_pkg::OFS_W-1:0]          drive_limit,
    input  logic signed [pdd_pkg::ERR_W-1:0]   error,
    input  logic signed [pdd_pkg::ERR_W-1:0]   prev_error,
    output pdd_pkg::law_result_t               result
);

    localparam int DIFF_W = pdd_pkg::ERR_W + 1;
    localparam int P_W    = pdd_pkg::GAIN_W + pdd_pkg::ERR_W;
    localparam int D_W    = pdd_pkg::GAIN_W + DIFF_W;
    localparam int RAW_W  = D_W + 1;
    localparam int SUM_W  = RAW_W + 1;
    localparam int CMD_W  = pdd_pkg::DRV_W + 1;
    localparam logic [RAW_W-1:0] FRAC_MASK =
        RAW_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    logic signed [DIFF_W-1:0] diff;
    logic signed [P_W-1:0]    p_prod;
    logic signed [D_W-1:0]    d_prod;
    logic signed [RAW_W-1:0]  raw;
    logic signed [RAW_W-1:0]  biased;
    logic signed [RAW_W-1:0]  quot;
    logic signed [SUM_W-1:0]  quot_ext;
    logic signed [SUM_W-1:0]  fric_ext;
    logic signed [SUM_W-1:0]  lim_ext;
    logic signed [SUM_W-1:0]  adjusted;
    logic signed [SUM_W-1:0]  clamped;
    logic signed [CMD_W-1:0]  cmd;
    logic [CMD_W-1:0]         mag;

    always_comb
    begin
        diff   = DIFF_W'(error) - DIFF_W'(prev_error);
        p_prod = P_W'(axis_cfg.p_gain) * P_W'(error);
        d_prod = D_W'(axis_cfg.d_gain) * D_W'(diff);
        raw    = RAW_W'(p_prod) + RAW_W'(d_prod);

        // A negative sum is biased up before the shift so that the
        // quotient truncates toward zero rather than toward minus infinity.
        biased = raw + (raw[RAW_W-1] ? signed'(FRAC_MASK) : RAW_W'(0));
        quot   = biased >>> GAIN_FRAC_BITS;

        quot_ext = SUM_W'(quot);
        fric_ext = signed'({{(SUM_W-pdd_pkg::OFS_W){1'b0}}, axis_cfg.friction});
        lim_ext  = signed'({{(SUM_W-pdd_pkg::OFS_W){1'b0}}, drive_limit});

        if (quot_ext > 0)
        begin
            adjusted = quot_ext + fric_ext;
        end
        else if (quot_ext < 0)
        begin
            adjusted = quot_ext - fric_ext;
        end
        else
        begin
            adjusted = '0;
        end

        if (adjusted > lim_ext)
        begin
            clamped = lim_ext;
        end
        else if (adjusted < -lim_ext)
        begin
            clamped = -lim_ext;
        end
        else
        begin
            clamped = adjusted;
        end

        // The vertical motor is mounted the other way round.
        cmd = axis ? -CMD_W'(clamped) : CMD_W'(clamped);
        mag = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);

        result.drive_value     = clamped[pdd_pkg::DRV_W-1:0];
        result.motor_direction = ~cmd[CMD_W-1];
        result.motor_duty      = (mag > CMD_W'(pdd_pkg::DUTY_MAX)) ?
                                 pdd_pkg::DUTY_MAX : mag[pdd_pkg::DUTY_W-1:0];
    end

endmodule

/* design/pd_position_drive_unit.sv */
// ----------------------------------------------------------------------------
// pd_position_drive_unit: two-axis PD position controller
// Top level with the request register, per-axis error memory, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
// Each request names an axis and carries its measured and target position;
// one drive result comes back for every request, in order, via the request
// and result registers. One request can be taken in every cycle unless drive
// results stall: the only work is the control law between the two registers,
// and the axis's previous error is written as the result register loads, so
// a following request on the same axis already sees it. The result register
// holds a finished drive while the request register takes the next request.
// Configuration writes are always accepted and take effect on the next
// cycle; they should only be made while no request is in flight.
module pd_position_drive_unit #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pdd_pos_if.sink              position,
    pdd_drive_if.source          drive,
    pdd_cfg_if.sink              cfg
);

    // Configuration registers.
    logic signed [pdd_pkg::GAIN_W-1:0] p_gain_x_reg;
    logic signed [pdd_pkg::GAIN_W-1:0] d_gain_x_reg;
    logic signed [pdd_pkg::GAIN_W-1:0] p_gain_y_reg;
    logic signed [pdd_pkg::GAIN_W-1:0] d_gain_y_reg;
    logic [pdd_pkg::OFS_W-1:0]         friction_x_reg;
    logic [pdd_pkg::OFS_W-1:0]         friction_y_reg;
    logic [pdd_pkg::OFS_W-1:0]         drive_limit_reg;

    // Request register.
    logic                              req_valid_reg;
    logic                              req_axis_reg;
    logic signed [pdd_pkg::POS_W-1:0]  req_meas_reg;
    logic signed [pdd_pkg::POS_W-1:0]  req_tgt_reg;

    // Previous error, one entry per axis.
    logic signed [pdd_pkg::ERR_W-1:0]  prev_error_reg [2];

    // Result register.
    logic                              res_valid_reg;
    logic                              res_axis_reg;
    pdd_pkg::law_result_t              res_reg;

    logic                              req_take;
    logic                              res_load;
    logic signed [pdd_pkg::ERR_W-1:0]  error;
    pdd_pkg::axis_cfg_t                axis_cfg;
    pdd_pkg::law_result_t              law_result;

    // The result register loads when it is empty or its drive is being taken;
    // the request register refills whenever its contents move on.
    assign res_load       = ~res_valid_reg | drive.ready;
    assign position.ready = ~req_valid_reg | res_load;
    assign req_take       = position.valid & position.ready;
    assign cfg.ready      = 1'b1;

    assign error = pdd_pkg::ERR_W'(req_tgt_reg) - pdd_pkg::ERR_W'(req_meas_reg);

    always_comb
    begin
        if (req_axis_reg)
        begin
            axis_cfg.p_gain   = p_gain_y_reg;
            axis_cfg.d_gain   = d_gain_y_reg;
            axis_cfg.friction = friction_y_reg;
        end
        else
        begin
            axis_cfg.p_gain   = p_gain_x_reg;
            axis_cfg.d_gain   = d_gain_x_reg;
            axis_cfg.friction = friction_x_reg;
        end
    end

    pdd_law #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_law (
        .axis        (req_axis_reg),
        .axis_cfg    (axis_cfg),
        .drive_limit (drive_limit_reg),
        .error       (error),
        .prev_error  (prev_error_reg[req_axis_reg]),
        .result      (law_result)
    );

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_x_reg    <= pdd_pkg::RST_P_GAIN_X;
            d_gain_x_reg    <= pdd_pkg::RST_D_GAIN_X;
            p_gain_y_reg    <= pdd_pkg::RST_P_GAIN_Y;
            d_gain_y_reg    <= pdd_pkg::RST_D_GAIN_Y;
            friction_x_reg  <= pdd_pkg::RST_FRICTION_X;
            friction_y_reg  <= pdd_pkg::RST_FRICTION_Y;
            drive_limit_reg <= pdd_pkg::RST_DRIVE_LIMIT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (pdd_pkg::cfg_index_t'(cfg.index))
                pdd_pkg::CFG_P_GAIN_X:          p_gain_x_reg    <= signed'(cfg.data);
                pdd_pkg::CFG_D_GAIN_X:          d_gain_x_reg    <= signed'(cfg.data);
                pdd_pkg::CFG_P_GAIN_Y:          p_gain_y_reg    <= signed'(cfg.data);
                pdd_pkg::CFG_D_GAIN_Y:          d_gain_y_reg    <= signed'(cfg.data);
                pdd_pkg::CFG_FRICTION_OFFSET_X:
                    friction_x_reg  <= cfg.data[pdd_pkg::OFS_W-1:0];
                pdd_pkg::CFG_FRICTION_OFFSET_Y:
                    friction_y_reg  <= cfg.data[pdd_pkg::OFS_W-1:0];
                pdd_pkg::CFG_DRIVE_LIMIT:
                    drive_limit_reg <= cfg.data[pdd_pkg::OFS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state: occupancy of both registers and the error memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg     <= 1'b0;
            res_valid_reg     <= 1'b0;
            prev_error_reg[0] <= '0;
            prev_error_reg[1] <= '0;
        end
        else
        begin
            if (position.ready)
            begin
                req_valid_reg <= position.valid;
            end
            if (res_load)
            begin
                res_valid_reg <= req_valid_reg;
                if (req_valid_reg)
                begin
                    prev_error_reg[req_axis_reg] <= error;
                end
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_axis_reg <= position.axis;
            req_meas_reg <= position.measured_position;
            req_tgt_reg  <= position.target_position;
        end
        if (res_load && req_valid_reg)
        begin
            res_axis_reg <= req_axis_reg;
            res_reg      <= law_result;
        end
    end

    assign drive.valid           = res_valid_reg;
    assign drive.axis_out        = res_axis_reg;
    assign drive.drive_value     = res_reg.drive_value;
    assign drive.motor_direction = res_reg.motor_direction;
    assign drive.motor_duty      = res_reg.motor_duty;

endmodule

/* design/pdd_checker.sv */
// ----------------------------------------------------------------------------
// pdd_checker: port-level assertions for the position drive unit
// Watches the drive result channel and checks that its fields agree.
// ----------------------------------------------------------------------------
module pdd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              axis_out,
    input logic signed [pdd_pkg::DRV_W-1:0]  drive_value,
    input logic                              motor_direction,
    input logic [pdd_pkg::DUTY_W-1:0]        motor_duty
);

    // A stalled result keeps its fields.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(axis_out)
            && $stable(drive_value) && $stable(motor_direction)
            && $stable(motor_duty))
        else $error("drive result changed while stalled");

    // Direction follows the drive sign, inverted on the vertical axis.
    a_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_value != 0 |->
            motor_direction == (axis_out ? drive_value < 0 : drive_value > 0))
        else $error("motor direction disagrees with drive sign");

    // A zero drive gives a forward direction and no duty.
    a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_value == 0 |-> motor_direction && motor_duty == 0)
        else $error("zero drive with nonzero duty or reverse direction");

    // The duty is the drive magnitude, saturated at full scale.
    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_value >= 0
            ? (drive_value > 1000 ? motor_duty == pdd_pkg::DUTY_MAX
                                  : 11'(motor_duty) == drive_value)
            : (drive_value < -1000 ? motor_duty == pdd_pkg::DUTY_MAX
                                   : 11'(motor_duty) == -drive_value)))
        else $error("motor duty disagrees with drive magnitude");

endmodule

bind pd_position_drive_unit pdd_checker u_pdd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (drive.valid),
    .out_ready       (drive.ready),
    .axis_out        (drive.axis_out),
    .drive_value     (drive.drive_value),
    .motor_direction (drive.motor_direction),
    .motor_duty      (drive.motor_duty)
);
